>>> sv/aac_gge_pkg.sv
// Shared types, constants and bit-extraction functions for the AAC global gain extractor.
`default_nettype none

package aac_gge_pkg;

    // Syntactic element ids (top three bits of the first frame byte)
    localparam logic [2:0] ELEM_SCE = 3'd0;
    localparam logic [2:0] ELEM_CPE = 3'd1;

    // Window sequence code for eight short windows
    localparam logic [1:0] WIN_EIGHT_SHORT = 2'd2;

    // Gain start bit before the ms_mask skip
    localparam logic [7:0] START_LONG  = 8'd21;
    localparam logic [7:0] START_SHORT = 8'd25;

    localparam logic [1:0] MS_MASK_USED = 2'd1;

    // Element kind reported with each frame result
    localparam logic [1:0] KIND_MONO   = 2'd0;
    localparam logic [1:0] KIND_STEREO = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;
    localparam logic [1:0] KIND_SHORT  = 2'd3;

    localparam logic [7:0] POS_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] gain;
        logic [1:0] kind;
    } gge_frame_t;

    // Merge the gain bits that fall in frame byte number pos into acc.
    // Bits are numbered MSB first from the start of the frame.
    function automatic logic [7:0] take_bits(
        input logic [7:0] data,
        input logic [7:0] pos,
        input logic [7:0] start,
        input logic [7:0] acc
    );
        logic [10:0] idx;
        logic [10:0] rel;
        logic [10:0] lo;
        logic [7:0]  res;
        res = acc;
        lo  = {3'b000, start};
        for (int b = 0; b < 8; b++) begin
            idx = {pos, 3'(b)};
            rel = idx - lo;
            if ((idx >= lo) && (idx < lo + 11'd8)) begin
                res[~rel[2:0]] = res[~rel[2:0]] | data[~3'(b)];
            end
        end
        return res;
    endfunction

    // First bit of the stereo global gain, from frame bytes 1..3.
    function automatic logic [7:0] stereo_start(
        input logic [7:0] d1,
        input logic [7:0] d2,
        input logic [7:0] d3
    );
        logic [5:0] sfb;
        logic [1:0] mask;
        logic [7:0] start;
        logic [3:0] groups;
        logic [9:0] skip;
        if (d1[6:5] == WIN_EIGHT_SHORT) begin
            sfb    = {2'b00, d1[3:0]};
            mask   = {d2[0], d3[7]};
            start  = START_SHORT;
            groups = 4'd1 + 4'($countones(~d2[7:1]));
        end else begin
            sfb    = {d1[3:0], d2[7:6]};
            mask   = d2[4:3];
            start  = START_LONG;
            groups = 4'd1;
        end
        skip = sfb * groups;
        if (mask == MS_MASK_USED) begin
            start = start + skip[7:0];
        end
        return start;
    endfunction

endpackage

`default_nettype wire

>>> sv/aac_gge_frame.sv
// Per-byte frame parser: header capture, stereo gain bit gathering and gain selection.
`default_nettype none

module aac_gge_frame
    import aac_gge_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic       frame_outside_data,
    output logic            done,
    output gge_frame_t      frame
);

    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [7:0] hdr0_reg;
    logic [7:0] hdr1_reg;
    logic [7:0] hdr2_reg;
    logic [7:0] start_reg;
    logic [7:0] start_next;
    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [7:0] prev_gain_reg;
    logic [2:0] elem_id;

    always_comb
    begin
        start_next = start_reg;
        acc_next   = acc_reg;
        if (pos_reg == 8'd3) begin
            start_next = stereo_start(hdr1_reg, hdr2_reg, data_byte);
            acc_next   = take_bits(data_byte, 8'd3, start_next,
                                   take_bits(hdr2_reg, 8'd2, start_next, 8'd0));
        end else if (pos_reg > 8'd3) begin
            acc_next = take_bits(data_byte, pos_reg, start_reg, acc_reg);
        end
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
    end

    assign elem_id = hdr0_reg[7:5];
    assign done    = step && last_byte;

    always_comb
    begin
        if (frame_outside_data || (pos_reg < 8'd3)) begin
            frame.gain = 8'd0;
            frame.kind = KIND_SHORT;
        end else if (elem_id == ELEM_SCE) begin
            frame.gain = {hdr0_reg[0], hdr1_reg[7:1]};
            frame.kind = KIND_MONO;
        end else if (elem_id == ELEM_CPE) begin
            frame.gain = acc_next;
            frame.kind = KIND_STEREO;
        end else begin
            // previous gain is zero until a frame has ended
            frame.gain = prev_gain_reg;
            frame.kind = KIND_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= 8'd0;
            prev_gain_reg <= 8'd0;
        end else if (step) begin
            pos_reg <= last_byte ? 8'd0 : pos_next;
            if (last_byte) begin
                prev_gain_reg <= frame.gain;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) begin
            if (pos_reg == 8'd0) begin
                hdr0_reg <= data_byte;
            end
            if (pos_reg == 8'd1) begin
                hdr1_reg <= data_byte;
            end
            if (pos_reg == 8'd2) begin
                hdr2_reg <= data_byte;
            end
            start_reg <= start_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/aac_gge_stats.sv
// Running min/max tracking and the result output register.
`default_nettype none

module aac_gge_stats
    import aac_gge_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire gge_frame_t  frame,
    input  wire logic        m_axis_tready,
    output logic             free,
    output logic             m_axis_tvalid,
    output logic [23:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser
);

    logic       out_valid_reg;
    logic [7:0] min_reg;
    logic [7:0] max_reg;
    logic [7:0] min_next;
    logic [7:0] max_next;
    logic [7:0] gain_reg;
    logic [1:0] kind_reg;

    assign min_next = (frame.gain < min_reg) ? frame.gain : min_reg;
    assign max_next = (frame.gain > max_reg) ? frame.gain : max_reg;

    assign free          = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {max_reg, min_reg, gain_reg};
    assign m_axis_tuser  = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            min_reg       <= 8'hff;
            max_reg       <= 8'h00;
        end else if (load) begin
            out_valid_reg <= 1'b1;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            gain_reg <= frame.gain;
            kind_reg <= frame.kind;
        end
    end

endmodule

`default_nettype wire

>>> sv/aac_frame_global_gain_extractor_core.sv
// Top level of the AAC frame global gain extractor.
//
// Input stream: one raw AAC frame byte per transaction, tlast on the frame's
// final byte, tuser set on that final byte when the frame overruns the data area.
// Output stream: one transaction per frame, issued for the byte carrying tlast:
// gain, running minimum and running maximum in tdata, element kind in tuser
// (mono, stereo, other element repeating the previous gain, short or outside).
// The result is registered: the final byte passes through the input register,
// then the result register. Throughput: one byte per cycle while the result
// register is free, set by the single parse stage between the input and result
// registers.
// A stalled output holds its result; the input keeps accepting while the
// result register is free or being drained this cycle, so a byte that ends
// no frame still advances behind a full result register only when it drains.
// Reset clears the byte position, the previous gain, the running maximum
// (to 0) and minimum (to 255) and drops any pending transaction.
`default_nettype none

module aac_frame_global_gain_extractor_core
    import aac_gge_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tuser,   // [0] frame_outside_data
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] frame_gain, [15:8] min_gain,
                                             // [23:16] max_gain
    output logic [1:0]       m_axis_tuser    // [1:0] element_kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_outside_reg;
    logic       free;
    logic       step;
    logic       done;
    gge_frame_t frame;

    assign step          = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg    <= s_axis_tdata;
            in_last_reg    <= s_axis_tlast;
            in_outside_reg <= s_axis_tuser;
        end
    end

    aac_gge_frame u_frame (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .data_byte          (in_byte_reg),
        .last_byte          (in_last_reg),
        .frame_outside_data (in_outside_reg),
        .done               (done),
        .frame              (frame)
    );

    aac_gge_stats u_stats (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (done),
        .frame         (frame),
        .m_axis_tready (m_axis_tready),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> sv/aac_gge_checker.sv
// Port-level assertion checker for the AAC global gain extractor, bound to the top level.
`default_nettype none

module aac_gge_checker
    import aac_gge_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] <= m_axis_tdata[7:0])
                          && (m_axis_tdata[7:0] <= m_axis_tdata[23:16]))
        else $error("frame gain outside running min/max");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_SHORT) |-> m_axis_tdata[15:0] == 16'd0
                                                          || m_axis_tdata[7:0] == 8'd0)
        else $error("short or outside frame with nonzero gain");

    a_min_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready ##1 m_axis_tvalid
            |-> m_axis_tdata[15:8] <= $past(m_axis_tdata[15:8], 1)
                || !$past(m_axis_tvalid, 1))
        else $error("running minimum increased");

endmodule

bind aac_frame_global_gain_extractor_core aac_gge_checker u_aac_gge_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> test/tb_aac_frame_global_gain_extractor_core.sv
// Self-checking testbench for the AAC frame global gain extractor core.
`timescale 1ns / 1ps

import aac_gge_pkg::*;

// Predicts one result per frame from the accepted bytes and checks the output stream.
class frame_gain_scoreboard;
    typedef struct {
        logic [7:0] gain;
        logic [1:0] kind;
        logic [7:0] lo;
        logic [7:0] hi;
    } frame_result_t;

    frame_result_t expected_gains[$];
    int unsigned   errors;
    int unsigned   results_seen;

    logic [7:0] byte_pos;
    logic [7:0] hdr[4];
    logic [7:0] start_bit;
    logic [7:0] gain_acc;
    logic [7:0] prev_gain;
    logic       seen_frame;
    logic [7:0] run_min;
    logic [7:0] run_max;

    function new();
        errors       = 0;
        results_seen = 0;
        prev_gain    = 8'd0;
        seen_frame   = 1'b0;
        run_min      = 8'd255;
        run_max      = 8'd0;
        clear_frame();
    endfunction

    function void clear_frame();
        byte_pos  = 8'd0;
        start_bit = 8'd0;
        gain_acc  = 8'd0;
        for (int i = 0; i < 4; i++)
            hdr[i] = 8'd0;
    endfunction

    function int pending();
        return expected_gains.size();
    endfunction

    // OR into the accumulator the gain bits that fall in frame byte number p.
    function void merge_gain_bits(logic [7:0] data, int p);
        int idx;
        int first;
        first = start_bit;
        for (int b = 0; b < 8; b++) begin
            idx = p * 8 + b;
            if (idx >= first && idx < first + 8)
                gain_acc[7 - (idx - first)] = gain_acc[7 - (idx - first)] | data[7 - b];
        end
    endfunction

    // Skip ics_info and ms_mask to find the first stereo gain bit.
    function logic [7:0] cpe_gain_start();
        int sfb;
        int mask;
        int first;
        int groups;
        groups = 1;
        if (hdr[1][6:5] == WIN_EIGHT_SHORT) begin
            sfb   = hdr[1][3:0];
            mask  = {hdr[2][0], hdr[3][7]};
            first = START_SHORT;
            for (int b = 1; b < 8; b++)
                if (!hdr[2][b])
                    groups++;
        end else begin
            sfb   = {hdr[1][3:0], hdr[2][7:6]};
            mask  = hdr[2][4:3];
            first = START_LONG;
        end
        if (mask == MS_MASK_USED)
            first += sfb * groups;
        return first[7:0];
    endfunction

    function void note_byte(logic [7:0] data, logic last, logic outside);
        int p;
        frame_result_t r;
        p = byte_pos;
        if (p < 4)
            hdr[p] = data;
        if (p == 3) begin
            start_bit = cpe_gain_start();
            gain_acc  = 8'd0;
            for (int i = 0; i < 4; i++)
                merge_gain_bits(hdr[i], i);
        end else if (p > 3) begin
            merge_gain_bits(data, p);
        end
        if (byte_pos != POS_MAX)
            byte_pos++;
        if (!last)
            return;

        if (outside || p < 3) begin
            r.gain = 8'd0;
            r.kind = KIND_SHORT;
        end else begin
            case (hdr[0][7:5])
                ELEM_SCE: begin
                    r.gain = {hdr[0][0], hdr[1][7:1]};
                    r.kind = KIND_MONO;
                end
                ELEM_CPE: begin
                    r.gain = gain_acc;
                    r.kind = KIND_STEREO;
                end
                default: begin
                    r.gain = seen_frame ? prev_gain : 8'd0;
                    r.kind = KIND_OTHER;
                end
            endcase
        end
        if (r.gain < run_min)
            run_min = r.gain;
        if (r.gain > run_max)
            run_max = r.gain;
        prev_gain  = r.gain;
        seen_frame = 1'b1;
        clear_frame();
        r.lo = run_min;
        r.hi = run_max;
        expected_gains.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endfunction

    function void check_result(logic [23:0] tdata, logic [1:0] tuser);
        frame_result_t r;
        results_seen++;
        if (expected_gains.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%h",
                     $time, tdata, tuser);
            errors++;
            return;
        end
        r = expected_gains.pop_front();
        compare_field("frame_gain", r.gain, tdata[7:0]);
        compare_field("min_gain", r.lo, tdata[15:8]);
        compare_field("max_gain", r.hi, tdata[23:16]);
        compare_field("element_kind", {6'd0, r.kind}, {6'd0, tuser});
    endfunction
endclass

module tb_aac_frame_global_gain_extractor_core;
    import aac_gge_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    frame_gain_scoreboard gain_sb = new();

    int unsigned bytes_sent = 0;
    bit          calm = 1'b0;
    bit          long_hold_done = 1'b0;

    aac_frame_global_gain_extractor_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            gain_sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Output side: random back-pressure, plus one long hold-off once results flow.
    initial
    begin
        int idle_left;
        idle_left = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_left > 0) begin
                idle_left--;
                m_axis_tready = 1'b0;
            end else if (!long_hold_done && gain_sb.results_seen >= 30) begin
                long_hold_done = 1'b1;
                idle_left      = 149;
                m_axis_tready  = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                idle_left     = $urandom_range(0, 3);
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the transaction completes.
    task automatic send_byte(input logic [7:0] d, input logic last, input logic outside);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        s_axis_tlast  = last;
        s_axis_tuser  = outside;
        do
            @(posedge clk);
        while (!s_axis_tready);
        gain_sb.note_byte(d, last, outside);
        bytes_sent++;
    endtask

    // Bytes past the first four are random; the outside flag off the last byte is noise.
    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input int len, input logic outside);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            case (i)
                0:       d = b0;
                1:       d = b1;
                2:       d = b2;
                3:       d = b3;
                default: d = $urandom;
            endcase
            send_byte(d, i == len - 1,
                      (i == len - 1) ? outside : 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [7:0] h0, h1, h2, h3;
        logic       outside;
        int         pick;
        int         len;
        int         frame_idx;
        int unsigned stop_at;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Other element before any frame has ended: gain 0.
        send_frame(8'h40, 8'h12, 8'h34, 8'h56, 5, 1'b0);
        send_frame(8'h1E, 8'h01, 8'hFF, 8'hFF, 6, 1'b0);   // mono gain 0
        send_frame(8'h00, 8'h20, 8'h00, 8'h00, 4, 1'b0);   // mono gain 0x10
        send_frame(8'h01, 8'hFE, 8'h00, 8'h00, 4, 1'b0);   // mono gain 0xFF
        send_frame(8'hE0, 8'h00, 8'h00, 8'h00, 8, 1'b0);   // other repeats 0xFF
        send_frame(8'h20, 8'h00, 8'h00, 8'h00, 12, 1'b0);  // stereo long, no ms_mask
        send_frame(8'h3F, 8'h0F, 8'hC8, 8'hFF, 20, 1'b0);  // stereo long, max_sfb 63
        send_frame(8'h20, 8'h05, 8'h10, 8'hAA, 10, 1'b0);  // stereo long, mask 2
        send_frame(8'h20, 8'h05, 8'h18, 8'h55, 10, 1'b0);  // stereo long, mask 3
        // Eight short windows, eight groups: gain straddles the frame end.
        send_frame(8'h20, 8'h4F, 8'h00, 8'h80, 19, 1'b0);
        send_frame(8'h20, 8'h4F, 8'h00, 8'h80, 4, 1'b0);   // gain wholly past end
        send_frame(8'h20, 8'h4F, 8'hFE, 8'h80, 8, 1'b0);   // one window group
        send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 1, 1'b0);   // short frames
        send_frame(8'h01, 8'hFF, 8'hFF, 8'hFF, 2, 1'b0);
        send_frame(8'h01, 8'hFF, 8'hFF, 8'hFF, 3, 1'b0);
        send_frame(8'h01, 8'hFE, 8'h00, 8'h00, 6, 1'b1);   // outside data area
        send_frame(8'h01, 8'hFE, 8'h00, 8'h00, 2, 1'b1);
        send_frame(8'h00, 8'hAA, 8'h00, 8'h00, 300, 1'b0); // position saturates

        stop_at   = 1450;
        frame_idx = 0;
        while (bytes_sent < stop_at)
        begin
            if (bytes_sent + 250 > stop_at)
                calm = 1'b1;
            if (frame_idx == 30) begin
                // Pause until every pending result has drained.
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                while (gain_sb.pending() != 0) @(negedge clk);
            end
            h0 = $urandom;
            h1 = $urandom;
            h2 = $urandom;
            h3 = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                h0[7:5] = ELEM_SCE;
            end else if (pick < 85) begin
                h0[7:5] = ELEM_CPE;
                if ($urandom_range(0, 2) == 0)
                    h1[6:5] = WIN_EIGHT_SHORT;
                if ($urandom_range(0, 4) < 3) begin
                    if (h1[6:5] == WIN_EIGHT_SHORT)
                        {h2[0], h3[7]} = MS_MASK_USED;
                    else
                        h2[4:3] = MS_MASK_USED;
                end
            end else begin
                h0[7:5] = 3'($urandom_range(2, 7));
            end
            len     = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 24);
            outside = ($urandom_range(0, 19) == 0);
            send_frame(h0, h1, h2, h3, len, outside);
            frame_idx++;
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        while (gain_sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (gain_sb.errors == 0 && gain_sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
